// File: rtl/cau_pkg.sv
// Shared types, constants and helper functions for the complex arithmetic unit.
package cau_pkg;

    localparam int FIELD_W     = 32;  // width of every operand and result part
    localparam int OPC_W       = 4;
    localparam int STATUS_W    = 2;
    localparam int SUM_W       = 66;  // wide signed sums of products
    localparam int PROD_W      = 64;
    localparam int DIV_LO_BITS = 32;  // low dividend bits fed one per divider stage
    localparam int SQRT_STEPS  = 32;  // result bits of the integer square root

    typedef enum logic [OPC_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_EQ   = 4'd4,
        OP_INC  = 4'd5,
        OP_NEG  = 4'd6,
        OP_CONJ = 4'd7,
        OP_MAG  = 4'd8
    } cau_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK  = 2'd0,
        ST_SAT = 2'd1,
        ST_DZ  = 2'd2
    } cau_status_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] re;
        logic signed [FIELD_W-1:0] im;
        logic                      eq;
        logic [STATUS_W-1:0]       status;
    } cau_res_t;

    // Per-item state carried through the divider / square-root stages
    typedef struct packed {
        logic [OPC_W-1:0]         op;
        cau_res_t                 res;     // finished result for the short ops
        logic                     neg_re;
        logic                     neg_im;
        logic                     ovf_re;
        logic                     ovf_im;
        logic                     dz;
        logic [PROD_W-1:0]        d;       // divisor
        logic [PROD_W-1:0]        r_re;    // partial remainders
        logic [PROD_W-1:0]        r_im;
        logic [DIV_LO_BITS-1:0]   mlo_re;  // dividend bits still to feed
        logic [DIV_LO_BITS-1:0]   mlo_im;
        logic [PROD_W-1:0]        q_re;    // quotient bits so far
        logic [PROD_W-1:0]        q_im;
        logic [PROD_W-1:0]        sx;      // square-root remainder
        logic [PROD_W-1:0]        sr;      // square-root partial result
    } cau_iter_t;

    // Clamp a wide signed value to [-wmax-1, wmax]; bit 32 flags a clamp.
    function automatic logic [FIELD_W:0] sat_word(input logic signed [SUM_W-1:0] x,
                                                  input logic signed [SUM_W-1:0] wmax);
        logic signed [SUM_W-1:0] wmin;
        wmin = -wmax - 66'sd1;
        if (x > wmax) begin
            return {1'b1, wmax[FIELD_W-1:0]};
        end
        if (x < wmin) begin
            return {1'b1, wmin[FIELD_W-1:0]};
        end
        return {1'b0, x[FIELD_W-1:0]};
    endfunction

    // One restoring division step: shift in a dividend bit, subtract when it fits.
    function automatic logic [PROD_W:0] div_step(input logic [PROD_W-1:0] r,
                                                 input logic              b,
                                                 input logic [PROD_W-1:0] d);
        logic [PROD_W:0] t;
        logic [PROD_W:0] diff;
        t    = {r, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[PROD_W-1:0]};
        end
        return {1'b0, t[PROD_W-1:0]};
    endfunction

endpackage

// File: rtl/cau_in_if.sv
// Operand channel: opcode and two complex operands with valid/ready.
interface cau_in_if;
    logic                               valid;
    logic                               ready;
    logic [cau_pkg::OPC_W-1:0]          opcode;
    logic signed [cau_pkg::FIELD_W-1:0] a_re;
    logic signed [cau_pkg::FIELD_W-1:0] a_im;
    logic signed [cau_pkg::FIELD_W-1:0] b_re;
    logic signed [cau_pkg::FIELD_W-1:0] b_im;

    modport source (output valid, opcode, a_re, a_im, b_re, b_im, input ready);
    modport sink (input valid, opcode, a_re, a_im, b_re, b_im, output ready);
endinterface

// File: rtl/cau_out_if.sv
// Result channel: complex result, compare flag and status with valid/ready.
interface cau_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [cau_pkg::FIELD_W-1:0] res_re;
    logic signed [cau_pkg::FIELD_W-1:0] res_im;
    logic                               equal_flag;
    logic [cau_pkg::STATUS_W-1:0]       status;

    modport source (output valid, res_re, res_im, equal_flag, status, input ready);
    modport sink (input valid, res_re, res_im, equal_flag, status, output ready);
endinterface

// File: rtl/cau_front.sv
// Front stages: products, short ops, sums of products and divider/root setup.
module cau_front #(
    parameter int                      FRAC_BITS = 16,
    parameter logic signed [65:0]      W_MAX     = 66'sd2147483647
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    cau_in_if.sink              din,
    output logic                v_out,
    output cau_pkg::cau_iter_t  it_out
);

    localparam logic signed [65:0] ONE  = 66'sd1 <<< FRAC_BITS;
    localparam logic signed [65:0] HALF = ONE >>> 1;

    // ---------------- stage 1: products and short ops
    logic                 v1_reg;
    logic [3:0]           op1_reg;
    logic signed [63:0]   p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [63:0]   p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    cau_pkg::cau_res_t    res1_reg, res1_next;
    logic signed [31:0]   x4, x5;
    logic signed [65:0]   ar_x, ai_x, br_x, bi_x;
    logic [32:0]          sat_r, sat_i;

    assign din.ready = adv;

    assign ar_x = {{34{din.a_re[31]}}, din.a_re};
    assign ai_x = {{34{din.a_im[31]}}, din.a_im};
    assign br_x = {{34{din.b_re[31]}}, din.b_re};
    assign bi_x = {{34{din.b_im[31]}}, din.b_im};

    // Magnitude squares a; every other op squares b for the divisor
    assign x4 = (din.opcode == cau_pkg::OP_MAG) ? din.a_re : din.b_re;
    assign x5 = (din.opcode == cau_pkg::OP_MAG) ? din.a_im : din.b_im;

    assign p0_next = din.a_re * din.b_re;
    assign p1_next = din.a_im * din.b_im;
    assign p2_next = din.a_re * din.b_im;
    assign p3_next = din.a_im * din.b_re;
    assign p4_next = x4 * x4;
    assign p5_next = x5 * x5;

    always_comb
    begin
        res1_next = '0;
        sat_r     = '0;
        sat_i     = '0;
        unique case (din.opcode)
            cau_pkg::OP_ADD:
            begin
                sat_r = cau_pkg::sat_word(ar_x + br_x, W_MAX);
                sat_i = cau_pkg::sat_word(ai_x + bi_x, W_MAX);
            end
            cau_pkg::OP_SUB:
            begin
                sat_r = cau_pkg::sat_word(ar_x - br_x, W_MAX);
                sat_i = cau_pkg::sat_word(ai_x - bi_x, W_MAX);
            end
            cau_pkg::OP_INC:
            begin
                sat_r = cau_pkg::sat_word(ar_x + ONE, W_MAX);
                sat_i = cau_pkg::sat_word(ai_x + ONE, W_MAX);
            end
            cau_pkg::OP_NEG:
            begin
                sat_r = cau_pkg::sat_word(-ar_x, W_MAX);
                sat_i = cau_pkg::sat_word(-ai_x, W_MAX);
            end
            cau_pkg::OP_CONJ:
            begin
                sat_r = cau_pkg::sat_word(ar_x, W_MAX);
                sat_i = cau_pkg::sat_word(-ai_x, W_MAX);
            end
            cau_pkg::OP_EQ:
            begin
                res1_next.eq = (din.a_re == din.b_re) && (din.a_im == din.b_im);
            end
            default:
            begin
            end
        endcase
        res1_next.re     = sat_r[31:0];
        res1_next.im     = sat_i[31:0];
        res1_next.status = (sat_r[32] | sat_i[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= din.opcode;
            res1_reg <= res1_next;
            p0_reg   <= p0_next;
            p1_reg   <= p1_next;
            p2_reg   <= p2_next;
            p3_reg   <= p3_next;
            p4_reg   <= p4_next;
            p5_reg   <= p5_next;
        end
    end

    // ---------------- stage 2: sums of products
    logic                 v2_reg;
    logic [3:0]           op2_reg;
    cau_pkg::cau_res_t    res2_reg;
    logic signed [65:0]   mre_reg, mim_reg, mre_next, mim_next;
    logic signed [63:0]   nre_reg, nim_reg, nre_next, nim_next;
    logic [63:0]          d_reg, d_next;
    logic signed [64:0]   nre_sum;

    assign mre_next = {{2{p0_reg[63]}}, p0_reg} - {{2{p1_reg[63]}}, p1_reg} + HALF;
    assign mim_next = {{2{p2_reg[63]}}, p2_reg} + {{2{p3_reg[63]}}, p3_reg} + HALF;
    assign nre_sum  = {p0_reg[63], p0_reg} + {p1_reg[63], p1_reg};
    assign nim_next = p3_reg - p2_reg;
    assign d_next   = p4_reg + p5_reg;

    // Clamp the real numerator to the 64-bit range
    always_comb
    begin
        if (nre_sum[64] != nre_sum[63])
        begin
            nre_next = nre_sum[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end
        else
        begin
            nre_next = nre_sum[63:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg  <= op1_reg;
            res2_reg <= res1_reg;
            mre_reg  <= mre_next;
            mim_reg  <= mim_next;
            nre_reg  <= nre_next;
            nim_reg  <= nim_next;
            d_reg    <= d_next;
        end
    end

    // ---------------- stage 3: product rounding and divider/root setup
    cau_pkg::cau_iter_t   it_next;
    logic signed [65:0]   mr_sh, mi_sh;
    logic [32:0]          sat_mr, sat_mi;
    logic [63:0]          abs_re, abs_im;

    assign mr_sh  = mre_reg >>> FRAC_BITS;
    assign mi_sh  = mim_reg >>> FRAC_BITS;
    assign sat_mr = cau_pkg::sat_word(mr_sh, W_MAX);
    assign sat_mi = cau_pkg::sat_word(mi_sh, W_MAX);
    assign abs_re = nre_reg[63] ? (64'd0 - nre_reg) : nre_reg;
    assign abs_im = nim_reg[63] ? (64'd0 - nim_reg) : nim_reg;

    always_comb
    begin
        it_next     = '0;
        it_next.op  = op2_reg;
        it_next.res = res2_reg;
        if (op2_reg == cau_pkg::OP_MUL)
        begin
            it_next.res.re     = sat_mr[31:0];
            it_next.res.im     = sat_mi[31:0];
            it_next.res.status = (sat_mr[32] | sat_mi[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
        end
        it_next.neg_re = nre_reg[63];
        it_next.neg_im = nim_reg[63];
        // Integer part of 32 bits or more always saturates
        it_next.ovf_re = {32'd0, abs_re[63:32]} >= d_reg;
        it_next.ovf_im = {32'd0, abs_im[63:32]} >= d_reg;
        it_next.dz     = (d_reg == 64'd0);
        it_next.d      = d_reg;
        it_next.r_re   = {32'd0, abs_re[63:32]};
        it_next.r_im   = {32'd0, abs_im[63:32]};
        it_next.mlo_re = abs_re[31:0];
        it_next.mlo_im = abs_im[31:0];
        it_next.sx     = d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out <= 1'b0;
        end
        else if (adv)
        begin
            v_out <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_out <= it_next;
        end
    end

endmodule

// File: rtl/cau_step.sv
// One stage of the divider pipeline (both lanes) and, early on, one root step.
module cau_step #(
    parameter int STEP = 0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                v_in,
    input  cau_pkg::cau_iter_t  it_in,
    output logic                v_out,
    output cau_pkg::cau_iter_t  it_out
);

    localparam bit          SQ_ON  = (STEP < cau_pkg::SQRT_STEPS);
    localparam logic [63:0] SQ_BIT = SQ_ON ? (64'd1 << (62 - 2 * STEP)) : 64'd0;

    cau_pkg::cau_iter_t it_next;
    logic [64:0]        dre, dim;
    logic [63:0]        trial;

    assign dre   = cau_pkg::div_step(it_in.r_re, it_in.mlo_re[31], it_in.d);
    assign dim   = cau_pkg::div_step(it_in.r_im, it_in.mlo_im[31], it_in.d);
    assign trial = it_in.sr + SQ_BIT;

    always_comb
    begin
        it_next        = it_in;
        it_next.r_re   = dre[63:0];
        it_next.r_im   = dim[63:0];
        it_next.q_re   = {it_in.q_re[62:0], dre[64]};
        it_next.q_im   = {it_in.q_im[62:0], dim[64]};
        it_next.mlo_re = {it_in.mlo_re[30:0], 1'b0};
        it_next.mlo_im = {it_in.mlo_im[30:0], 1'b0};
        if (SQ_ON)
        begin
            if (it_in.sx >= trial)
            begin
                it_next.sx = it_in.sx - trial;
                it_next.sr = (it_in.sr >> 1) + SQ_BIT;
            end
            else
            begin
                it_next.sr = it_in.sr >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out <= 1'b0;
        end
        else if (adv)
        begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it_out <= it_next;
        end
    end

endmodule

// File: rtl/cau_back.sv
// Final stage: quotient and root rounding, saturation and result select.
module cau_back #(
    parameter logic signed [65:0] W_MAX = 66'sd2147483647
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic                v_in,
    input  cau_pkg::cau_iter_t  it_in,
    output logic                v_out,
    output cau_pkg::cau_res_t   res_out
);

    // Round half away from zero on the magnitude, apply sign, saturate
    function automatic logic [32:0] div_fin(input logic [63:0] q,
                                            input logic        neg,
                                            input logic        ovf);
        logic [64:0]        rq;
        logic signed [65:0] val;
        logic signed [65:0] wmin;
        wmin = -W_MAX - 66'sd1;
        rq   = ({1'b0, q} + 65'd1) >> 1;
        val  = $signed({1'b0, rq});
        if (neg)
        begin
            val = -val;
        end
        if (ovf)
        begin
            return {1'b1, neg ? wmin[31:0] : W_MAX[31:0]};
        end
        return cau_pkg::sat_word(val, W_MAX);
    endfunction

    cau_pkg::cau_res_t res_next;
    logic [32:0]       dr, di, sm;
    logic [64:0]       root;

    assign dr   = div_fin(it_in.q_re, it_in.neg_re, it_in.ovf_re);
    assign di   = div_fin(it_in.q_im, it_in.neg_im, it_in.ovf_im);
    // Round the root up when the remainder exceeds it
    assign root = {1'b0, it_in.sr} + {64'd0, (it_in.sx > it_in.sr)};
    assign sm   = cau_pkg::sat_word($signed({1'b0, root}), W_MAX);

    always_comb
    begin
        res_next = it_in.res;
        case (it_in.op)
            cau_pkg::OP_DIV:
            begin
                if (it_in.dz)
                begin
                    res_next        = '0;
                    res_next.status = cau_pkg::ST_DZ;
                end
                else
                begin
                    res_next.re     = dr[31:0];
                    res_next.im     = di[31:0];
                    res_next.eq     = 1'b0;
                    res_next.status = (dr[32] | di[32]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::OP_MAG:
            begin
                res_next.re     = sm[31:0];
                res_next.im     = '0;
                res_next.eq     = 1'b0;
                res_next.status = sm[32] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_out <= 1'b0;
        end
        else if (adv)
        begin
            v_out <= v_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_out <= res_next;
        end
    end

endmodule

// File: rtl/complex_arith_unit.sv
// Complex-number ALU: pipelined add, sub, mul, div, compare, inc, negate, conjugate, magnitude.
//
// Takes one operand beat per cycle while the skid buffer is empty; returns one result beat per
// operand beat, in order. The path is three front stages (products, sums, setup),
// 33 + FRAC_BITS restoring-division stages that each produce one quotient bit for the real and
// the imaginary lane (the first 32 of them also run one square-root step), one rounding stage
// and the output register. All ops take the same path, so order is kept. A one-entry skid
// buffer behind the output register keeps din.ready registered; the pipeline holds while that
// buffer is full.
module complex_arith_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    cau_in_if.sink     din,
    cau_out_if.source  dout
);

    localparam int EFF_BITS = (WORD_BITS > cau_pkg::FIELD_W) ? cau_pkg::FIELD_W : WORD_BITS;
    localparam logic signed [65:0] W_MAX = (66'sd1 <<< (EFF_BITS - 1)) - 66'sd1;
    localparam int N_STEPS = cau_pkg::DIV_LO_BITS + FRAC_BITS + 1;

    logic                adv;
    logic                v_pipe  [N_STEPS+1];
    cau_pkg::cau_iter_t  it_pipe [N_STEPS+1];
    logic                v_back;
    cau_pkg::cau_res_t   res_back;

    logic                out_v_reg, skid_v_reg;
    cau_pkg::cau_res_t   out_reg, skid_reg;
    logic                pop, push;

    assign adv = ~skid_v_reg;

    cau_front #(
        .FRAC_BITS (FRAC_BITS),
        .W_MAX     (W_MAX)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .adv    (adv),
        .din    (din),
        .v_out  (v_pipe[0]),
        .it_out (it_pipe[0])
    );

    for (genvar g = 0; g < N_STEPS; g++)
    begin : g_step
        cau_step #(
            .STEP (g)
        ) u_step (
            .clk    (clk),
            .rst_n  (rst_n),
            .adv    (adv),
            .v_in   (v_pipe[g]),
            .it_in  (it_pipe[g]),
            .v_out  (v_pipe[g+1]),
            .it_out (it_pipe[g+1])
        );
    end

    cau_back #(
        .W_MAX (W_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .v_in    (v_pipe[N_STEPS]),
        .it_in   (it_pipe[N_STEPS]),
        .v_out   (v_back),
        .res_out (res_back)
    );

    assign pop  = out_v_reg & dout.ready;
    assign push = adv & v_back;

    // Output register with one skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (skid_v_reg)
        begin
            if (pop)
            begin
                skid_v_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !pop)
            begin
                skid_v_reg <= 1'b1;
            end
            else
            begin
                out_v_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_v_reg)
        begin
            if (pop)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (push)
        begin
            if (out_v_reg && !pop)
            begin
                skid_reg <= res_back;
            end
            else
            begin
                out_reg <= res_back;
            end
        end
    end

    assign dout.valid      = out_v_reg;
    assign dout.res_re     = out_reg.re;
    assign dout.res_im     = out_reg.im;
    assign dout.equal_flag = out_reg.eq;
    assign dout.status     = out_reg.status;

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid entry held without an output beat");

    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_v_reg) |-> $past(out_v_reg && !dout.ready))
        else $error("skid filled while the output register was free");

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.status == cau_pkg::ST_DZ)
        |-> (dout.res_re == '0 && dout.res_im == '0 && !dout.equal_flag))
        else $error("divide-by-zero beat carries a nonzero result");

    a_eq_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.equal_flag)
        |-> (dout.status == cau_pkg::ST_OK && dout.res_re == '0 && dout.res_im == '0))
        else $error("compare beat carries a result or status");

endmodule
